/* rtl/brle_pkg.sv */
// Package for the byte run-length encoder: widths, record layout, queue defaults.
// No dependencies; every other file but brle_fifo refers to it by scoped names.
`default_nettype none
package brle_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 32;
  localparam int unsigned RecBytes   = 5;
  localparam int unsigned IdxW       = 4;   // byte index within up to two records
  localparam int unsigned QueueDepth = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Byte positions inside a queued entry (first record, then second record).
  localparam logic [IdxW-1:0] IdxVal0  = 4'd0;
  localparam logic [IdxW-1:0] IdxCnt0a = 4'd1;
  localparam logic [IdxW-1:0] IdxCnt0b = 4'd2;
  localparam logic [IdxW-1:0] IdxCnt0c = 4'd3;
  localparam logic [IdxW-1:0] IdxCnt0d = 4'd4;
  localparam logic [IdxW-1:0] IdxVal1  = 4'd5;
  localparam logic [IdxW-1:0] IdxCnt1a = 4'd6;
  localparam logic [IdxW-1:0] IdxCnt1b = 4'd7;
  localparam logic [IdxW-1:0] IdxCnt1c = 4'd8;
  localparam logic [IdxW-1:0] IdxCnt1d = 4'd9;

  // One or two closed runs produced by a single input item.
  typedef struct packed {
    logic              dbl;   // two records: closed run, then end-of-file run
    logic              eob;   // last record ends the compressed block
    logic [ByteW-1:0]  val0;
    logic [CountW-1:0] cnt0;
    logic [ByteW-1:0]  val1;
    logic [CountW-1:0] cnt1;
  } rec_pair_t;

endpackage
`default_nettype wire

/* rtl/brle_intf.sv */
// Valid/ready channel interfaces for the byte run-length encoder.
// Depends on brle_pkg for the payload widths.
`default_nettype none
interface brle_in_if;
  logic                        valid;
  logic                        ready;
  logic [brle_pkg::ByteW-1:0]  data_byte;
  logic                        end_of_file;

  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface brle_out_if;
  logic                        valid;
  logic                        ready;
  logic [brle_pkg::ByteW-1:0]  out_byte;
  logic                        last_of_item;
  logic                        end_of_block;

  modport source (output valid, out_byte, last_of_item, end_of_block, input ready);
  modport sink   (input valid, out_byte, last_of_item, end_of_block, output ready);
endinterface
`default_nettype wire

/* rtl/brle_front.sv */
// Front end: accepts input items, tracks the open run, queues closed runs.
// Depends on brle_pkg and brle_in_if.
`default_nettype none
module brle_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  brle_in_if.sink                  in_i,
  input  wire logic                full_i,
  output logic                     push_o,
  output brle_pkg::rec_pair_t      entry_o
);

  logic                              active_q, active_d;
  logic [brle_pkg::ByteW-1:0]        value_q, value_d;
  logic [brle_pkg::CountW-1:0]       length_q, length_d;
  logic                              accept;
  logic                              close;
  logic [brle_pkg::ByteW-1:0]        nv;
  logic [brle_pkg::CountW-1:0]       nl;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    close = 1'b0;
    nv    = in_i.data_byte;
    nl    = brle_pkg::CountW'(1);
    if (active_q && in_i.data_byte == value_q && length_q != brle_pkg::CountMax) begin
      nv = value_q;
      nl = length_q + brle_pkg::CountW'(1);
    end else if (active_q) begin
      close = 1'b1;
    end

    entry_o.dbl  = close && in_i.end_of_file;
    entry_o.eob  = in_i.end_of_file;
    entry_o.val0 = close ? value_q  : nv;
    entry_o.cnt0 = close ? length_q : nl;
    entry_o.val1 = nv;
    entry_o.cnt1 = nl;

    push_o = accept && (close || in_i.end_of_file);

    active_d = active_q;
    value_d  = value_q;
    length_d = length_q;
    if (accept) begin
      if (in_i.end_of_file) begin
        active_d = 1'b0;
        value_d  = '0;
        length_d = '0;
      end else begin
        active_d = 1'b1;
        value_d  = nv;
        length_d = nl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      value_q  <= '0;
      length_q <= '0;
    end else begin
      active_q <= active_d;
      value_q  <= value_d;
      length_q <= length_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/brle_fifo.sv */
// Small register queue between front and back ends.
// No dependencies beyond its parameters.
`default_nettype none
module brle_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [Width-1:0]      rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/brle_back.sv */
// Back end: serializes queued records into bytes through an output register.
// Depends on brle_pkg and brle_out_if.
`default_nettype none
module brle_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire brle_pkg::rec_pair_t  entry_i,
  output logic                      pop_o,
  brle_out_if.source                out_o
);

  brle_pkg::rec_pair_t               cur_q;
  logic                              cur_valid_q, cur_valid_d;
  logic [brle_pkg::IdxW-1:0]         idx_q, idx_d;
  logic                              out_valid_q, out_valid_d;
  logic [brle_pkg::ByteW-1:0]        out_byte_q;
  logic                              out_last_q, out_eob_q;
  logic [brle_pkg::ByteW-1:0]        sel_byte;
  logic [brle_pkg::IdxW-1:0]         last_idx;
  logic                              advance, at_last;

  assign last_idx = cur_q.dbl ? brle_pkg::IdxCnt1d : brle_pkg::IdxCnt0d;
  assign at_last  = (idx_q == last_idx);
  assign advance  = cur_valid_q && (!out_valid_q || out_o.ready);
  assign pop_o    = valid_i && (!cur_valid_q || (advance && at_last));

  always_comb begin
    case (idx_q)
      brle_pkg::IdxVal0:  sel_byte = cur_q.val0;
      brle_pkg::IdxCnt0a: sel_byte = cur_q.cnt0[7:0];
      brle_pkg::IdxCnt0b: sel_byte = cur_q.cnt0[15:8];
      brle_pkg::IdxCnt0c: sel_byte = cur_q.cnt0[23:16];
      brle_pkg::IdxCnt0d: sel_byte = cur_q.cnt0[31:24];
      brle_pkg::IdxVal1:  sel_byte = cur_q.val1;
      brle_pkg::IdxCnt1a: sel_byte = cur_q.cnt1[7:0];
      brle_pkg::IdxCnt1b: sel_byte = cur_q.cnt1[15:8];
      brle_pkg::IdxCnt1c: sel_byte = cur_q.cnt1[23:16];
      brle_pkg::IdxCnt1d: sel_byte = cur_q.cnt1[31:24];
      default:            sel_byte = '0;
    endcase
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end else if (advance && at_last) begin
      cur_valid_d = 1'b0;
    end else if (advance) begin
      idx_d = idx_q + brle_pkg::IdxW'(1);
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    if (advance) begin
      out_byte_q <= sel_byte;
      out_last_q <= at_last;
      out_eob_q  <= at_last && cur_q.eob;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.last_of_item = out_last_q;
  assign out_o.end_of_block = out_eob_q;

endmodule
`default_nettype wire

/* rtl/byte_run_length_encoder_top.sv */
// Byte run-length encoder, top level. A closing item's records pass the record
// queue, the back end's current-record register and its output register in turn.
// Throughput: one output byte per cycle while the output is ready; an item that closes
// a run gives 5 output bytes (10 when it also ends the file) on the one-byte output port.
// Input is taken every cycle while the record queue has room.
// Reset (async, active low) discards any open run and empties queue and output.
`default_nettype none
module byte_run_length_encoder_top #(
  parameter int unsigned QueueDepth = brle_pkg::QueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  brle_in_if.sink     in_i,
  brle_out_if.source  out_o
);

  // Front end -> queue: one entry per item that closes at least one run.
  brle_pkg::rec_pair_t  push_entry;
  logic                 push;
  logic                 full;

  // Queue -> back end.
  brle_pkg::rec_pair_t  head_entry;
  logic                 head_valid;
  logic                 pop;

  // Run tracking: extends, closes or flushes the open run per item.
  brle_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Decouples run tracking from byte serialization.
  brle_fifo #(
    .Width ($bits(brle_pkg::rec_pair_t)),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_entry)
  );

  // Emits value byte then count LSB first, per record, with item/block flags.
  brle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
